// ===== src/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, codes and types of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Field widths
  localparam int ACT_W  = 2;
  localparam int REQ_W  = 25;
  localparam int OFF_W  = 24;
  localparam int ID_W   = 32;
  localparam int CLS_W  = 5;
  localparam int STAT_W = 2;

  // Smallest block is 1 << MIN_BLOCK_SHIFT bytes
  localparam int MIN_BLOCK_SHIFT = 2;

  // Defaults for the top-level parameters
  localparam int DESCRIPTOR_SLOTS_DEF = 1024;
  localparam int SIZE_CLASSES_DEF     = 23;

  localparam logic [ID_W-1:0] ID_RESET = 32'hF000_0000;

  // Request codes
  localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  // One descriptor table entry
  typedef struct packed {
    logic             in_tbl;
    logic             alloc;
    logic [CLS_W-1:0] cls;
    logic [OFF_W-1:0] offset;
    logic [ID_W-1:0]  id;
    logic [ID_W-1:0]  refs;
  } desc_t;

  // One result transaction
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  offset;
    logic [CLS_W-1:0]  cls;
    logic [ID_W-1:0]   id;
  } result_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DECODE, S_ADV,
    S_GRAB, S_GRAB_WR,
    S_SPL_FIND, S_SPL_EMPTY, S_SPL_WA, S_SPL_WB, S_SPL_WP, S_SPL_RET,
    S_MRG_OUT, S_MRG_BUD, S_MRG_WT, S_MRG_EMPTY, S_MRG_WN, S_MRG_WS, S_MRG_NEXT,
    S_FREE, S_RECLAIM, S_LOOKUP, S_LOOK_WR, S_DONE
  } ctrl_state_t;

  // Steps of an allocation
  typedef enum logic [2:0] {
    PH_GRAB1, PH_SPLIT, PH_GRAB2, PH_MERGE1, PH_GRAB3, PH_RECLAIM, PH_MERGE2, PH_GRAB4
  } phase_t;

endpackage

// ===== src/buddy_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy-style block allocator over a descriptor table held in one memory.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one request per transaction, allocate,
// free by offset, or look up offset and id and count a reference.
// Output channel (out_valid/out_ready): exactly one result per request.
// Every free, lookup and allocate that fits a class walks the descriptor
// table through the single read port of the table memory, one entry per
// cycle. A free, or a lookup that finds no match, walks the whole table
// before out_valid rises; a lookup stops its walk at the matching entry.
// An allocate that finds a free block of its class is served within one
// table walk; each further step (split at one level, merge of one class,
// reclaim) costs one or more further table walks, and each merge
// candidate adds a buddy walk and, when the buddy is found, a free-slot
// walk. One request is worked on at a time; in_ready is high only
// while the sequencer is idle.
// After reset the table is cleared by a pass over all DESCRIPTOR_SLOTS
// entries, during which no request is taken.
// A finished result sits in an output register; while the receiver stalls,
// the next request is still taken and worked on up to its result, which then
// waits until the output register frees.
// ----------------------------------------------------------------------------
module buddy_block_allocator import bba_pkg::*; #(
  parameter int DESCRIPTOR_SLOTS = DESCRIPTOR_SLOTS_DEF,
  parameter int SIZE_CLASSES     = SIZE_CLASSES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [REQ_W-1:0]  in_request_bytes,
  input  logic [OFF_W-1:0]  in_block_offset,
  input  logic [ID_W-1:0]   in_block_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [OFF_W-1:0]  out_result_offset,
  output logic [CLS_W-1:0]  out_size_class,
  output logic [ID_W-1:0]   out_result_id
);

  localparam int AW = $clog2(DESCRIPTOR_SLOTS);

  logic          res_valid, res_take;
  result_t       res;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  desc_t         rd_data, wr_data;
  logic          out_valid_r;
  result_t       out_res_r;

  bba_ctrl #(
    .DESCRIPTOR_SLOTS (DESCRIPTOR_SLOTS),
    .SIZE_CLASSES     (SIZE_CLASSES),
    .AW               (AW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_request_bytes (in_request_bytes),
    .in_block_offset  (in_block_offset),
    .in_block_id      (in_block_id),
    .res_valid        (res_valid),
    .res_take         (res_take),
    .res              (res),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data)
  );

  bba_desc_mem #(
    .DEPTH (DESCRIPTOR_SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // output register: load when empty or being drained
  assign res_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_result_offset = out_res_r.offset;
  assign out_size_class    = out_res_r.cls;
  assign out_result_id     = out_res_r.id;

endmodule

// ===== src/bba_desc_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_desc_mem
// Descriptor table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bba_desc_mem import bba_pkg::*; #(
  parameter int DEPTH = DESCRIPTOR_SLOTS_DEF,
  parameter int AW    = $clog2(DESCRIPTOR_SLOTS_DEF)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output desc_t         rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  desc_t         wr_data
);

  desc_t mem_r [DEPTH];
  desc_t rd_data_r;

  // write and read; read data is registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/bba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: scans the descriptor table and reads, modifies and
// writes back entries for allocate, split, merge, reclaim, free and lookup.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; #(
  parameter int DESCRIPTOR_SLOTS = DESCRIPTOR_SLOTS_DEF,
  parameter int SIZE_CLASSES     = SIZE_CLASSES_DEF,
  parameter int AW               = $clog2(DESCRIPTOR_SLOTS_DEF)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ACT_W-1:0] in_action,
  input  logic [REQ_W-1:0] in_request_bytes,
  input  logic [OFF_W-1:0] in_block_offset,
  input  logic [ID_W-1:0]  in_block_id,
  output logic             res_valid,
  input  logic             res_take,
  output result_t          res,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  input  desc_t            rd_data,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output desc_t            wr_data
);

  localparam int CW  = $clog2(DESCRIPTOR_SLOTS + 1);
  localparam int CBW = MIN_BLOCK_SHIFT + SIZE_CLASSES;
  localparam int NW  = ((CBW > OFF_W) ? CBW : OFF_W) + 1;
  localparam logic [CW-1:0]    SLOTS_C = CW'(DESCRIPTOR_SLOTS);
  localparam logic [CW-1:0]    LAST_C  = CW'(DESCRIPTOR_SLOTS - 1);
  localparam logic [CLS_W-1:0] TOP_CLS = CLS_W'(SIZE_CLASSES - 1);
  localparam logic [CLS_W:0]   NCLS_C  = (CLS_W+1)'(SIZE_CLASSES);

  // block size of class k, wide enough for the whole pool
  function automatic logic [NW-1:0] blk_bytes(input logic [CLS_W-1:0] k);
    logic [CLS_W:0] sh;
    sh = {1'b0, k} + (CLS_W+1)'(MIN_BLOCK_SHIFT);
    return {{(NW-1){1'b0}}, 1'b1} << sh;
  endfunction

  // fresh free descriptor
  function automatic desc_t new_desc(input logic [CLS_W-1:0] k,
                                     input logic [OFF_W-1:0] off);
    desc_t d;
    d        = '0;
    d.in_tbl = 1'b1;
    d.cls    = k;
    d.offset = off;
    return d;
  endfunction

  ctrl_state_t state_r, state_nxt;
  phase_t      phase_r, phase_nxt;

  logic [ACT_W-1:0] act_r, act_nxt;
  logic [REQ_W-1:0] req_r, req_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [ID_W-1:0]  bid_r, bid_nxt;
  logic [CLS_W-1:0] k_r, k_nxt;
  logic [CLS_W-1:0] lvl_r, lvl_nxt;
  logic             second_r, second_nxt;
  logic             split_ok_r, split_ok_nxt;
  logic [CLS_W-1:0] mcls_r, mcls_nxt;
  logic             freed_r, freed_nxt;
  logic [CW-1:0]    issue_r, issue_nxt;
  logic             dv_r, dv_nxt;
  logic [AW-1:0]    daddr_r, daddr_nxt;
  logic [AW-1:0]    hit_addr_r, hit_addr_nxt;
  desc_t            hit_ent_r, hit_ent_nxt;
  logic [AW-1:0]    a_r, a_nxt;
  logic [AW-1:0]    b_r, b_nxt;
  logic             have_a_r, have_a_nxt;
  logic [AW-1:0]    s_r, s_nxt;
  logic [OFF_W-1:0] s_off_r, s_off_nxt;
  logic [NW-1:0]    next_r, next_nxt;
  logic [ID_W-1:0]  id_ctr_r, id_ctr_nxt;
  result_t          res_r, res_nxt;

  logic             scan_st, scan_end, match, hit;
  logic [CLS_W-1:0] k_sel;
  logic             k_ok;
  logic             can_split, go_up, at_root, mrg_last;
  logic [NW-1:0]    rd_off_ext, split_hi;

  // smallest class that holds the request
  always_comb begin
    k_sel = '0;
    k_ok  = 1'b0;
    for (int i = SIZE_CLASSES - 1; i >= 0; i--) begin
      if (blk_bytes(CLS_W'(i)) >= NW'(req_r)) begin
        k_sel = CLS_W'(i);
        k_ok  = 1'b1;
      end
    end
  end

  // scan bookkeeping
  assign scan_st  = state_r inside {S_GRAB, S_SPL_FIND, S_SPL_EMPTY, S_MRG_OUT, S_MRG_BUD,
                                    S_MRG_EMPTY, S_FREE, S_RECLAIM, S_LOOKUP};
  assign scan_end = !dv_r && (issue_r == SLOTS_C);
  assign rd_off_ext = NW'(rd_data.offset);
  assign split_hi   = NW'(hit_ent_r.offset) + blk_bytes(lvl_r - CLS_W'(1));

  assign can_split = ({1'b0, k_r} + (CLS_W+1)'(1)) < NCLS_C;
  assign go_up     = !second_r && !split_ok_r && (({1'b0, lvl_r} + (CLS_W+1)'(1)) < NCLS_C);
  assign at_root   = {1'b0, lvl_r} == ({1'b0, k_r} + (CLS_W+1)'(1));
  assign mrg_last  = (mcls_r + CLS_W'(1)) == k_r;

  // entry match for the running scan
  always_comb begin
    match = 1'b0;
    case (state_r)
      S_GRAB:     match = rd_data.in_tbl && !rd_data.alloc && rd_data.cls == k_r;
      S_SPL_FIND: match = rd_data.in_tbl && !rd_data.alloc && rd_data.cls == lvl_r;
      S_SPL_EMPTY,
      S_MRG_EMPTY: match = !rd_data.in_tbl;
      S_MRG_OUT:  match = rd_data.in_tbl && !rd_data.alloc && rd_data.cls == mcls_r &&
                          ((rd_off_ext & ((blk_bytes(mcls_r) << 1) - NW'(1))) == '0);
      S_MRG_BUD:  match = rd_data.in_tbl && !rd_data.alloc && rd_data.cls == mcls_r &&
                          rd_off_ext == next_r;
      S_FREE:     match = rd_data.in_tbl && rd_data.alloc && rd_data.offset == off_r;
      S_RECLAIM:  match = rd_data.in_tbl && rd_data.alloc && rd_data.refs == '0;
      S_LOOKUP:   match = rd_data.in_tbl && rd_data.alloc && rd_data.offset == off_r &&
                          rd_data.id == bid_r;
      default:    match = 1'b0;
    endcase
  end

  assign hit = dv_r && match;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:   if (issue_r == LAST_C) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        case (act_r)
          ACT_ALLOC:  state_nxt = k_ok ? S_ADV : S_DONE;
          ACT_FREE:   state_nxt = S_FREE;
          ACT_LOOKUP: state_nxt = S_LOOKUP;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_ADV: begin
        case (phase_r)
          PH_GRAB1, PH_GRAB2, PH_GRAB3, PH_GRAB4: state_nxt = S_GRAB;
          PH_SPLIT:   state_nxt = can_split ? S_SPL_FIND : S_ADV;
          PH_MERGE1, PH_MERGE2: state_nxt = (k_r != '0) ? S_MRG_OUT : S_ADV;
          PH_RECLAIM: state_nxt = S_RECLAIM;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_GRAB: begin
        if (hit) state_nxt = S_GRAB_WR;
        else if (scan_end) state_nxt = (phase_r == PH_GRAB4) ? S_DONE : S_ADV;
      end
      S_GRAB_WR:   state_nxt = S_DONE;
      S_SPL_FIND: begin
        if (hit) state_nxt = S_SPL_EMPTY;
        else if (scan_end) state_nxt = S_SPL_RET;
      end
      S_SPL_EMPTY: begin
        if (hit && have_a_r) state_nxt = S_SPL_WA;
        else if (scan_end) state_nxt = S_SPL_RET;
      end
      S_SPL_WA:    state_nxt = S_SPL_WB;
      S_SPL_WB:    state_nxt = S_SPL_WP;
      S_SPL_WP:    state_nxt = S_SPL_RET;
      S_SPL_RET:   state_nxt = (!go_up && at_root) ? S_ADV : S_SPL_FIND;
      S_MRG_OUT: begin
        if (hit) state_nxt = S_MRG_BUD;
        else if (scan_end) state_nxt = S_MRG_NEXT;
      end
      S_MRG_NEXT:  state_nxt = mrg_last ? S_ADV : S_MRG_OUT;
      S_MRG_BUD: begin
        if (hit) state_nxt = S_MRG_WT;
        else if (scan_end) state_nxt = S_MRG_OUT;
      end
      S_MRG_WT:    state_nxt = S_MRG_EMPTY;
      S_MRG_EMPTY: begin
        if (hit) state_nxt = S_MRG_WN;
        else if (scan_end) state_nxt = S_MRG_WS;
      end
      S_MRG_WN:    state_nxt = S_MRG_WS;
      S_MRG_WS:    state_nxt = S_MRG_OUT;
      S_FREE:      if (scan_end) state_nxt = S_DONE;
      S_RECLAIM:   if (scan_end) state_nxt = freed_r ? S_ADV : S_DONE;
      S_LOOKUP: begin
        if (hit) state_nxt = S_LOOK_WR;
        else if (scan_end) state_nxt = S_DONE;
      end
      S_LOOK_WR:   state_nxt = S_DONE;
      S_DONE:      if (res_take) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // outputs: handshake and memory ports
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    res_valid = (state_r == S_DONE);
    res       = res_r;
    rd_en     = scan_st && (issue_r != SLOTS_C) && (state_nxt == state_r);
    rd_addr   = issue_r[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = hit_addr_r;
    wr_data   = '0;
    case (state_r)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = issue_r[AW-1:0];
        if (issue_r == '0) wr_data = new_desc(TOP_CLS, '0);
      end
      S_GRAB_WR: begin
        wr_en         = 1'b1;
        wr_data       = hit_ent_r;
        wr_data.alloc = 1'b1;
        wr_data.refs  = '0;
        wr_data.id    = id_ctr_r + ID_W'(1);
      end
      S_LOOK_WR: begin
        wr_en        = 1'b1;
        wr_data      = hit_ent_r;
        wr_data.refs = hit_ent_r.refs + ID_W'(1);
      end
      S_FREE, S_RECLAIM: begin
        wr_en         = hit;
        wr_addr       = daddr_r;
        wr_data       = rd_data;
        wr_data.alloc = 1'b0;
      end
      S_SPL_WA: begin
        wr_en   = 1'b1;
        wr_addr = a_r;
        wr_data = new_desc(lvl_r - CLS_W'(1), hit_ent_r.offset);
      end
      S_SPL_WB: begin
        wr_en   = 1'b1;
        wr_addr = b_r;
        wr_data = new_desc(lvl_r - CLS_W'(1), split_hi[OFF_W-1:0]);
      end
      S_SPL_WP, S_MRG_WT: begin
        wr_en = 1'b1;
      end
      S_MRG_WN: begin
        wr_en   = 1'b1;
        wr_addr = a_r;
        wr_data = new_desc(mcls_r + CLS_W'(1), s_off_r);
      end
      S_MRG_WS: begin
        wr_en   = 1'b1;
        wr_addr = s_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // datapath next values
  always_comb begin
    phase_nxt    = phase_r;
    act_nxt      = act_r;
    req_nxt      = req_r;
    off_nxt      = off_r;
    bid_nxt      = bid_r;
    k_nxt        = k_r;
    lvl_nxt      = lvl_r;
    second_nxt   = second_r;
    split_ok_nxt = split_ok_r;
    mcls_nxt     = mcls_r;
    freed_nxt    = freed_r;
    hit_addr_nxt = hit_addr_r;
    hit_ent_nxt  = hit_ent_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    have_a_nxt   = have_a_r;
    s_nxt        = s_r;
    s_off_nxt    = s_off_r;
    next_nxt     = next_r;
    id_ctr_nxt   = id_ctr_r;
    res_nxt      = res_r;
    dv_nxt       = rd_en;
    daddr_nxt    = issue_r[AW-1:0];

    // advance the scan pointer; restart on every new scan, but resume the outer merge scan after its last candidate
    issue_nxt = issue_r;
    if (state_r == S_INIT || rd_en) issue_nxt = issue_r + CW'(1);
    if (state_nxt != state_r) begin
      if (state_nxt == S_MRG_OUT && (state_r == S_MRG_BUD || state_r == S_MRG_WS))
        issue_nxt = CW'(s_r) + CW'(1);
      else
        issue_nxt = '0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt = in_action;
          req_nxt = in_request_bytes;
          off_nxt = in_block_offset;
          bid_nxt = in_block_id;
          res_nxt = '0;
        end
      end
      S_DECODE: begin
        case (act_r)
          ACT_ALLOC: begin
            if (k_ok) begin
              k_nxt     = k_sel;
              phase_nxt = PH_GRAB1;
            end else begin
              res_nxt.status = ST_TOO_LARGE;
            end
          end
          ACT_FREE, ACT_LOOKUP: res_nxt.status = ST_OK;
          default: res_nxt.status = ST_NOT_FOUND;
        endcase
      end
      S_ADV: begin
        case (phase_r)
          PH_SPLIT: begin
            if (can_split) begin
              lvl_nxt    = k_r + CLS_W'(1);
              second_nxt = 1'b0;
            end else begin
              phase_nxt = PH_MERGE1;
            end
          end
          PH_MERGE1, PH_MERGE2: begin
            if (k_r != '0) mcls_nxt = '0;
            else phase_nxt = (phase_r == PH_MERGE1) ? PH_GRAB3 : PH_GRAB4;
          end
          PH_RECLAIM: freed_nxt = 1'b0;
          default: freed_nxt = freed_r;
        endcase
      end
      S_GRAB: begin
        if (hit) begin
          hit_addr_nxt = daddr_r;
          hit_ent_nxt  = rd_data;
        end else if (scan_end) begin
          case (phase_r)
            PH_GRAB1: phase_nxt = PH_SPLIT;
            PH_GRAB2: phase_nxt = PH_MERGE1;
            PH_GRAB3: phase_nxt = PH_RECLAIM;
            default:  res_nxt.status = ST_NO_SPACE;
          endcase
        end
      end
      S_GRAB_WR: begin
        id_ctr_nxt     = id_ctr_r + ID_W'(1);
        res_nxt.status = ST_OK;
        res_nxt.offset = hit_ent_r.offset;
        res_nxt.cls    = hit_ent_r.cls;
        res_nxt.id     = id_ctr_r + ID_W'(1);
      end
      S_SPL_FIND: begin
        if (hit) begin
          hit_addr_nxt = daddr_r;
          hit_ent_nxt  = rd_data;
          have_a_nxt   = 1'b0;
        end else if (scan_end) begin
          split_ok_nxt = 1'b0;
        end
      end
      S_SPL_EMPTY: begin
        if (hit) begin
          if (!have_a_r) begin
            a_nxt      = daddr_r;
            have_a_nxt = 1'b1;
          end else begin
            b_nxt = daddr_r;
          end
        end else if (scan_end) begin
          split_ok_nxt = 1'b0;
        end
      end
      S_SPL_WP: split_ok_nxt = 1'b1;
      // unwind the split recursion: climb on failure, retry one level down on return
      S_SPL_RET: begin
        if (go_up) begin
          lvl_nxt = lvl_r + CLS_W'(1);
        end else if (at_root) begin
          phase_nxt = split_ok_r ? PH_GRAB2 : PH_MERGE1;
        end else begin
          lvl_nxt    = lvl_r - CLS_W'(1);
          second_nxt = 1'b1;
        end
      end
      S_MRG_OUT: begin
        if (hit) begin
          s_nxt     = daddr_r;
          s_off_nxt = rd_data.offset;
          next_nxt  = rd_off_ext + blk_bytes(mcls_r);
        end
      end
      S_MRG_NEXT: begin
        if (mrg_last) phase_nxt = (phase_r == PH_MERGE1) ? PH_GRAB3 : PH_GRAB4;
        else mcls_nxt = mcls_r + CLS_W'(1);
      end
      S_MRG_BUD: if (hit) hit_addr_nxt = daddr_r;
      S_MRG_EMPTY: if (hit) a_nxt = daddr_r;
      S_RECLAIM: begin
        if (hit) freed_nxt = 1'b1;
        else if (scan_end) begin
          if (freed_r) phase_nxt = PH_MERGE2;
          else res_nxt.status = ST_NO_SPACE;
        end
      end
      S_LOOKUP: begin
        if (hit) begin
          hit_addr_nxt = daddr_r;
          hit_ent_nxt  = rd_data;
        end else if (scan_end) begin
          res_nxt.status = ST_NOT_FOUND;
        end
      end
      S_LOOK_WR: begin
        res_nxt.status = ST_OK;
        res_nxt.offset = hit_ent_r.offset;
        res_nxt.cls    = hit_ent_r.cls;
        res_nxt.id     = hit_ent_r.id;
      end
      default: res_nxt = res_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      phase_r  <= PH_GRAB1;
      issue_r  <= '0;
      dv_r     <= 1'b0;
      id_ctr_r <= ID_RESET;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      issue_r  <= issue_nxt;
      dv_r     <= dv_nxt;
      id_ctr_r <= id_ctr_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    req_r      <= req_nxt;
    off_r      <= off_nxt;
    bid_r      <= bid_nxt;
    k_r        <= k_nxt;
    lvl_r      <= lvl_nxt;
    second_r   <= second_nxt;
    split_ok_r <= split_ok_nxt;
    mcls_r     <= mcls_nxt;
    freed_r    <= freed_nxt;
    daddr_r    <= daddr_nxt;
    hit_addr_r <= hit_addr_nxt;
    hit_ent_r  <= hit_ent_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    have_a_r   <= have_a_nxt;
    s_r        <= s_nxt;
    s_off_r    <= s_off_nxt;
    next_r     <= next_nxt;
    res_r      <= res_nxt;
  end

  // write-back never lands on the entry being read
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en && wr_addr == rd_addr))
    else $error("read and write of the same descriptor in one cycle");

  // id counter moves only when a block is stamped
  a_id_on_grab: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && id_ctr_r != $past(id_ctr_r)) |-> $past(state_r) == S_GRAB_WR)
    else $error("id counter changed outside an allocation write");

  // failed requests report zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status != ST_OK) |-> (res.offset == '0 && res.cls == '0 && res.id == '0))
    else $error("failed request carries nonzero fields");

endmodule
